/* design/bol_pkg.sv */
`timescale 1ns / 1ps

package bol_pkg;

  localparam int VALUE_W   = 32;
  localparam int POS_W     = 7;
  localparam int ENTRY_W   = 7;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_END   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL_POS   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DUMP      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_COUNT     = 3'd6;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]           status;
    logic signed [VALUE_W-1:0] element;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      last;
  } res_t;

endpackage

/* design/bounded_ordered_list.sv */
`timescale 1ns / 1ps

// channel  dir  handshake                       payload
// in       in   in_tvalid / in_tready           tuser action, tdata value | position
// out      out  out_tvalid / out_tready         tuser status, tdata element | entry_count,
//                                               tlast last
//
// insert end, delete last, count and refused edits: from accept straight to S_RES, then the result
// shifting deletes: a store read and a write per moved entry, through the single store read port, then S_RES
// insert front on a filled list: a read and a write per moved entry, then the front write and S_RES
// dump: per value a store read, then a result
// reset is synchronous; entry count clears, store contents stay undefined
// the block takes no item until its last result enters the output register

module bounded_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bol_pkg::IN_DATA_W-1:0]  in_tdata,   // value[31:0], position[38:32]
  input  logic [bol_pkg::ACT_W-1:0]      in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bol_pkg::OUT_DATA_W-1:0] out_tdata,  // element[31:0], entry_count[38:32]
  output logic [bol_pkg::ST_W-1:0]       out_tuser,  // status
  output logic                           out_tlast
);
  import bol_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MV_RD  = 3'd1;
  localparam logic [2:0] S_MV_WR  = 3'd2;
  localparam logic [2:0] S_INS0   = 3'd3;
  localparam logic [2:0] S_DP_RD  = 3'd4;
  localparam logic [2:0] S_DP_OUT = 3'd5;
  localparam logic [2:0] S_RES    = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      dst_r, dst_nxt;
  logic               up_r, up_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;

  logic               in_acc;
  logic [ACT_W-1:0]   in_action;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_position;
  logic [POS_W-1:0]   pos_m1;
  logic [AW-1:0]      del_k;
  logic               del_bad;
  logic               full;
  logic               empty;
  logic [AW-1:0]      src;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               dump_last;

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_action   = in_tuser;
  assign in_value    = in_tdata[31:0];
  assign in_position = in_tdata[38:32];

  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign pos_m1 = in_position - POS_W'(1);

  // shared address step: source of the next move, also the next destination
  assign src = up_r ? dst_r - AW'(1) : dst_r + AW'(1);

  assign dump_last = ((CW'(dst_r) + CW'(1)) == count_r);

  always_comb begin
    del_k   = '0;
    del_bad = 1'b0;
    case (in_action)
      ACT_DEL_LAST: begin
        del_k = AW'(count_r - CW'(1));
      end
      ACT_DEL_POS: begin
        del_k   = pos_m1[AW-1:0];
        del_bad = (in_position == '0) || (in_position > ENTRY_W'(count_r));
      end
      default: begin
        del_k = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    dst_nxt    = dst_r;
    up_nxt     = up_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = dst_r;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = src;
    res_valid  = 1'b0;
    res.status      = status_r;
    res.element     = '0;
    res.entry_count = ENTRY_W'(count_r);
    res.last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt    = in_value;
          status_nxt = ST_OK;
          state_nxt  = S_RES;
          case (in_action)
            ACT_INS_FRONT, ACT_INS_END: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else if (in_action == ACT_INS_END || empty) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end else begin
                up_nxt    = 1'b1;
                dst_nxt   = count_r[AW-1:0];
                state_nxt = S_MV_RD;
              end
            end
            ACT_DEL_FIRST, ACT_DEL_LAST, ACT_DEL_POS: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (del_bad) begin
                status_nxt = ST_INVALID;
              end else if (CW'(del_k) == count_r - CW'(1)) begin
                count_nxt = count_r - CW'(1);
              end else begin
                up_nxt    = 1'b0;
                dst_nxt   = del_k;
                state_nxt = S_MV_RD;
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                dst_nxt   = '0;
                state_nxt = S_DP_RD;
              end
            end
            ACT_COUNT: begin
              status_nxt = ST_OK;
            end
            default: begin
              status_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = src;
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        dst_nxt   = src;
        if (up_r) begin
          state_nxt = (src == '0) ? S_INS0 : S_MV_RD;
        end else if (CW'(src) == count_r - CW'(1)) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RES;
        end else begin
          state_nxt = S_MV_RD;
        end
      end
      S_INS0: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RES;
      end
      S_DP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = dst_r;
        state_nxt = S_DP_OUT;
      end
      S_DP_OUT: begin
        res_valid   = 1'b1;
        res.status  = ST_OK;
        res.element = mem_rdata;
        res.last    = dump_last;
        if (res_ready) begin
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            dst_nxt   = dst_r + AW'(1);
            state_nxt = S_DP_RD;
          end
        end
      end
      S_RES: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    dst_r    <= dst_nxt;
    up_r     <= up_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

  bol_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bol_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) ||
                      count_r == $past(count_r) + CW'(1) ||
                      count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item taken while previous item still in work");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store read and write in the same cycle");

  a_partial_only_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.last) |-> (state_r == S_DP_OUT && !empty))
    else $error("non-final result outside a dump");

endmodule

/* design/bol_store.sv */
`timescale 1ns / 1ps

module bol_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bol_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bol_pkg::VALUE_W-1:0] rdata
);
  import bol_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/bol_outreg.sv */
`timescale 1ns / 1ps

module bol_outreg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           res_valid,
  input  bol_pkg::res_t                  res,
  output logic                           res_ready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bol_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [bol_pkg::ST_W-1:0]       out_tuser,
  output logic                           out_tlast
);
  import bol_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign res_ready = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {1'b0, res_r.entry_count, res_r.element};
  assign out_tuser  = res_r.status;
  assign out_tlast  = res_r.last;

endmodule
